### src/qphi_pkg.sv
package qphi_pkg;

    localparam int TABLE_DEPTH = 16384;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int M_W         = SLOT_W + 1;
    localparam int CFG_W       = 15;
    localparam int KEY_W       = 31;
    localparam int KCNT_W      = $clog2(KEY_W);
    localparam int CMP_W       = (CFG_W > M_W) ? CFG_W : M_W;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = CFG_W'(16381);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_INIT,
        ST_READ,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load_key;
        logic div_step;
        logic probe_init;
        logic probe_adv;
        logic mark;
        logic res_load;
        logic res_placed;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic m_zero;
        logic probe_free;
        logic probe_last;
        logic out_free;
    } t_sts;

endpackage

### src/qphi_key_if.sv
interface qphi_key_if;
    import qphi_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);

endinterface

### src/qphi_res_if.sv
interface qphi_res_if;
    import qphi_pkg::*;

    logic              valid;
    logic              ready;
    logic              placed;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output placed, output slot_index, input ready);
    modport sink   (input valid, input placed, input slot_index, output ready);

endinterface

### src/qphi_ctrl.sv
module qphi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output qphi_pkg::t_cmd   o_cmd,
    input  qphi_pkg::t_sts   i_sts
);
    import qphi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_key = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.m_zero) begin
                    // no slots at all: fail without touching the table
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.div_done) begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.probe_init = 1'b1;
                n_state          = ST_READ;
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.probe_free) begin
                    if (i_sts.out_free) begin
                        o_cmd.mark       = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_placed = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else if (i_sts.probe_last) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.probe_adv = 1'b1;
                    n_state         = ST_READ;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

### src/qphi_dp.sv
module qphi_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qphi_pkg::t_cmd                i_cmd,
    output qphi_pkg::t_sts                o_sts,
    input  logic [qphi_pkg::KEY_W-1:0]    i_key,
    input  logic [qphi_pkg::CFG_W-1:0]    i_table_size,
    qphi_res_if.source                    o_res
);
    import qphi_pkg::*;

    logic                mem [TABLE_DEPTH];
    logic                r_rd;

    logic [SLOT_W-1:0]   r_clr_addr;
    logic [M_W-1:0]      r_m;
    logic [KEY_W-1:0]    r_key;
    logic [KCNT_W-1:0]   r_kcnt;
    logic [M_W-1:0]      r_rem;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_d;
    logic [M_W-1:0]      r_cnt;

    logic                r_out_valid;
    logic                r_placed;
    logic [SLOT_W-1:0]   r_slot_out;

    logic [CMP_W-1:0]    ts_ext;
    logic [M_W-1:0]      eff_m;
    logic [M_W:0]        div_trial;
    logic [M_W:0]        div_next;
    logic [M_W-1:0]      slot_sum;
    logic [M_W-1:0]      slot_next;
    logic [M_W-1:0]      d_sum;
    logic [M_W-1:0]      d_next;
    logic                out_free;

    assign ts_ext = CMP_W'(i_table_size);
    assign eff_m  = (ts_ext > CMP_W'(TABLE_DEPTH)) ? M_W'(TABLE_DEPTH) : M_W'(ts_ext);

    // restoring remainder, one key bit per cycle
    assign div_trial = {r_rem, r_key[KEY_W-1]};
    assign div_next  = (div_trial >= {1'b0, r_m}) ? (div_trial - {1'b0, r_m}) : div_trial;

    // slot(i+1) = slot(i) + (2i+1) mod m, and (2i+1) mod m steps by 2
    assign slot_sum  = {1'b0, r_slot} + {1'b0, r_d};
    assign slot_next = (slot_sum >= r_m) ? (slot_sum - r_m) : slot_sum;
    assign d_sum     = {1'b0, r_d} + M_W'(2);
    assign d_next    = (d_sum >= r_m) ? (d_sum - r_m) : d_sum;

    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.mark) begin
            mem[r_slot] <= 1'b1;
        end
        r_rd <= mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + SLOT_W'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_m    <= eff_m;
            r_key  <= i_key;
            r_kcnt <= KCNT_W'(KEY_W - 1);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_key  <= {r_key[KEY_W-2:0], 1'b0};
            r_kcnt <= r_kcnt - KCNT_W'(1);
            r_rem  <= div_next[M_W-1:0];
        end
        if (i_cmd.probe_init) begin
            r_slot <= r_rem[SLOT_W-1:0];
            r_d    <= (r_m == M_W'(1)) ? '0 : SLOT_W'(1);
            r_cnt  <= M_W'(1);
        end else if (i_cmd.probe_adv) begin
            r_slot <= slot_next[SLOT_W-1:0];
            r_d    <= d_next[SLOT_W-1:0];
            r_cnt  <= r_cnt + M_W'(1);
        end
        if (i_cmd.res_load) begin
            r_placed   <= i_cmd.res_placed;
            r_slot_out <= i_cmd.res_placed ? r_slot : '0;
        end
    end

    assign o_sts.clr_done   = (r_clr_addr == '1);
    assign o_sts.div_done   = (r_kcnt == '0);
    assign o_sts.m_zero     = (r_m == '0);
    assign o_sts.probe_free = !r_rd;
    assign o_sts.probe_last = (r_cnt == r_m);
    assign o_sts.out_free   = out_free;

    assign o_res.valid      = r_out_valid;
    assign o_res.placed     = r_placed;
    assign o_res.slot_index = r_slot_out;

endmodule

### src/quadratic_probe_hash_insert_core.sv
// Flow from key accept to result valid: a bit-serial key mod size, a start of the probe walk,
//   then a memory read and a check per probe, up to table-size probes (at least one).
// One key is handled at a time; a zero table size fails without the division or the walk.
// The result register lets the next key enter while a result waits to be taken.
// Reset (synchronous, active low): a clearing pass over every slot of the table (one slot per cycle)
//   runs before the first key is accepted; table_size returns to 16381.
module quadratic_probe_hash_insert_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    qphi_key_if.sink                    i_key_ch,
    qphi_res_if.source                  o_res_ch,
    input  logic                        i_cfg_we,
    input  logic [qphi_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import qphi_pkg::*;

    logic [CFG_W-1:0] r_table_size;
    t_cmd             cmd;
    t_sts             sts;
    logic             in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_wdata;
        end
    end

    assign i_key_ch.ready = in_ready;

    qphi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key_ch.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    qphi_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_key        (i_key_ch.key),
        .i_table_size (r_table_size),
        .o_res        (o_res_ch)
    );

endmodule

### src/qphi_chk.sv
module qphi_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_placed,
    input logic [qphi_pkg::SLOT_W-1:0]  i_out_slot
);
    import qphi_pkg::*;

    // reset empties the result register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a failed insert reports slot zero
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_placed) |-> (i_out_slot == '0))
        else $error("failed insert with nonzero slot");

    // one item at a time: no accept right after an accept
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind quadratic_probe_hash_insert_core qphi_chk u_qphi_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_key_ch.valid),
    .i_in_ready   (i_key_ch.ready),
    .i_out_valid  (o_res_ch.valid),
    .i_out_ready  (o_res_ch.ready),
    .i_out_placed (o_res_ch.placed),
    .i_out_slot   (o_res_ch.slot_index)
);

### test/tb_quadratic_probe_hash_insert_core.sv
`timescale 1ns / 100ps

module tb_quadratic_probe_hash_insert_core;
    import qphi_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned RANDOM_ITEMS = 1620;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned MAX_PRINTS   = 100;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef struct packed {
        logic              placed;
        logic [SLOT_W-1:0] slot_index;
    } insert_result_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    qphi_key_if key_ch ();
    qphi_res_if res_ch ();

    quadratic_probe_hash_insert_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_ch    (key_ch),
        .o_res_ch    (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mirror of the block state
    bit               slot_taken [TABLE_DEPTH];
    logic [CFG_W-1:0] cur_table_size;
    insert_result_t   placements_q [$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_cycles = 0;
    int unsigned ready_gap   = 0;
    bit          src_stalls  = 1'b0;
    bit          sink_stalls = 1'b0;

    int unsigned small_primes [15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items pending", cycle_count,
                     placements_q.size());
            $display("tb_quadratic_probe_hash_insert_core: FAIL");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(0, 3);
    endfunction

    // Walk (home + i*i) mod m and take the first free slot.
    function automatic insert_result_t place_key(input logic [KEY_W-1:0] key);
        insert_result_t   r;
        longint unsigned  m;
        longint unsigned  home;
        longint unsigned  slot;
        longint unsigned  i;
        r = '0;
        m = (cur_table_size > TABLE_DEPTH) ? TABLE_DEPTH : cur_table_size;
        if (m == 0) begin
            return r;
        end
        home = key % m;
        for (i = 0; i < m; i++) begin
            slot = (home + (i * i) % m) % m;
            if (!slot_taken[slot]) begin
                slot_taken[slot] = 1'b1;
                r.placed     = 1'b1;
                r.slot_index = slot[SLOT_W-1:0];
                return r;
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] random_key(input int unsigned m);
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom);
        case ($urandom_range(0, 4))
            0: begin
                k = KEY_W'($urandom_range(0, 255));
            end
            1: begin
                // lands near the bottom of the table, where slots are crowded
                k = KEY_W'(m * $urandom_range(0, 1000) + $urandom_range(0, 3));
            end
            2: begin
                k = {1'b1, 30'($urandom)};
            end
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [CFG_W-1:0] pick_table_size();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 7) begin
            return CFG_W'(small_primes[$urandom_range(0, 14)]);
        end
        if (pick < 10) begin
            return CFG_W'($urandom_range(0, 64));
        end
        if (pick < 16) begin
            return CFG_W'($urandom_range(65, 4000));
        end
        if (pick < 18) begin
            return CFG_W'($urandom_range(4001, 16384));
        end
        return CFG_W'($urandom_range(16381, 32767));
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // result side: long hold-off on request, else random gaps while sink stalls are enabled
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            res_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else if (ready_gap != 0) begin
            res_ch.ready <= 1'b0;
            ready_gap    <= ready_gap - 1;
        end else begin
            res_ch.ready <= 1'b1;
            if (sink_stalls && $urandom_range(0, 2) == 0) begin
                ready_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        insert_result_t want;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (placements_q.size() == 0) begin
                report_mismatch($sformatf("unexpected item: placed=%0b slot=%0d",
                                          res_ch.placed, res_ch.slot_index));
            end else begin
                want = placements_q.pop_front();
                if (res_ch.placed !== want.placed) begin
                    report_mismatch($sformatf("placed: got %b want %b",
                                              res_ch.placed, want.placed));
                end
                if (res_ch.slot_index !== want.slot_index) begin
                    report_mismatch($sformatf("slot_index: got %0d want %0d",
                                              res_ch.slot_index, want.slot_index));
                end
            end
        end
    end

    task automatic apply_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (slot_taken[n]) begin
            slot_taken[n] = 1'b0;
        end
        cur_table_size = TABLE_SIZE_RESET;
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key, input int unsigned gap);
        insert_result_t r;
        key_ch.valid <= 1'b1;
        key_ch.key   <= key;
        do @(posedge i_clk); while (key_ch.ready !== 1'b1);
        r = place_key(key);
        placements_q.push_back(r);
        if (gap != 0) begin
            key_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        key_ch.valid <= 1'b0;
        while (placements_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [CFG_W-1:0] size);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_table_size = size;
    endtask

    // reset size; key zero, key extremes and a collision on the home slot
    task automatic test_reset_size();
        sink_stalls = 1'b1;
        send_key(31'd1, 0);
        send_key(31'd16381, $urandom_range(0, 2));
        send_key(31'd0, 0);
        send_key(KEY_MAX, $urandom_range(0, 2));
        send_key(31'd16382, 0);
        send_key(31'h2AAA_AAAA, 0);
    endtask

    task automatic test_zero_size();
        write_table_size('0);
        send_key(31'd5, 0);
        send_key(31'd0, 1);
        send_key(KEY_MAX, 0);
    endtask

    // sizes above the table depth saturate
    task automatic test_oversized_size();
        write_table_size(CFG_W'(32767));
        send_key(31'(16384 * 5 + 100), 0);
        send_key(KEY_MAX, 0);
        write_table_size(CFG_W'(TABLE_DEPTH));
        send_key(31'd16383, 0);
        send_key(31'h5555_5555, 2);
    endtask

    // full probe walk on a crowded small table, then a resize keeps the bits
    task automatic test_tiny_and_resize();
        write_table_size(CFG_W'(1));
        send_key(31'd9, 0);
        write_table_size(CFG_W'(3));
        send_key(31'd4, 0);
        send_key(31'd2, 0);
        write_table_size(CFG_W'(5));
        send_key(31'd3, 0);
    endtask

    task automatic test_backpressure();
        write_table_size(TABLE_SIZE_RESET);
        src_stalls  = 1'b0;
        sink_stalls = 1'b0;
        hold_cycles = 400;
        repeat (10) begin
            send_key(random_key(TABLE_SIZE_RESET), 0);
        end
        wait_for_results();
    endtask

    task automatic test_random_inserts(input int unsigned total);
        int unsigned      sent;
        int unsigned      burst;
        int unsigned      m;
        logic [CFG_W-1:0] size;
        sent = 0;
        while (sent < total) begin
            size = pick_table_size();
            write_table_size(size);
            m = (size > TABLE_DEPTH) ? TABLE_DEPTH : size;
            burst = (m <= 64) ? $urandom_range(1, 2 * m + 2) : $urandom_range(10, 50);
            src_stalls  = ($urandom_range(0, 2) != 0);
            sink_stalls = ($urandom_range(0, 2) != 0);
            repeat (burst) begin
                send_key(random_key(m), src_stalls ? pick_gap() : 0);
            end
            sent += burst;
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        key_ch.valid = 1'b0;
        key_ch.key   = '0;
        res_ch.ready = 1'b0;

        apply_reset();
        test_reset_size();
        test_zero_size();
        test_oversized_size();
        test_tiny_and_resize();
        test_backpressure();
        test_random_inserts(RANDOM_ITEMS);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_quadratic_probe_hash_insert_core: PASS");
        end else begin
            $display("tb_quadratic_probe_hash_insert_core: FAIL");
        end
        $finish;
    end

endmodule

### quadratic_probe_hash_insert_core.f
src/qphi_pkg.sv
src/qphi_key_if.sv
src/qphi_res_if.sv
src/qphi_ctrl.sv
src/qphi_dp.sv
src/quadratic_probe_hash_insert_core.sv
src/qphi_chk.sv
test/tb_quadratic_probe_hash_insert_core.sv
